// File: rtl/rmj_pkg.sv
// rmj_pkg: shared types, widths and helpers for the radar measurement jacobian
// used by rmj_div_cell, rmj_sqrt_cell and radar_measurement_jacobian
`default_nettype none

package rmj_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int THR_W  = 31;

   // most positive word, as a 64-bit magnitude
   localparam logic [63:0] SMAX_POS = (64'd1 << (DATA_W - 1)) - 64'd1;
   localparam logic [63:0] SMAX_NEG = (64'd1 << (DATA_W - 1));

   // one restoring division step: partial remainder, dividend bits msb first
   typedef struct packed {
      logic [63:0] part;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quo;
   } div_type;

   // one square root digit step: remainder, root so far, radicand bits msb first
   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sqrt_type;

   // sign and magnitude to a saturated two's complement word
   function automatic logic [DATA_W-1:0] sat_word(input logic neg, input logic [63:0] mag);
      logic [63:0] m;
      m = mag;
      if (neg) begin
         if (m > SMAX_NEG) m = SMAX_NEG;
         return DATA_W'(64'd0 - m);
      end else begin
         if (m > SMAX_POS) m = SMAX_POS;
         return m[DATA_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/rmj_div_cell.sv
// rmj_div_cell: one restoring division step, one quotient bit per cycle while en is high
// depends on rmj_pkg (div_type)
`default_nettype none

module rmj_div_cell import rmj_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  div_type div_prev,
   output div_type div_next
);

   div_type     div_ff;
   div_type     div_in;
   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;

   // shift in the next dividend bit and try a subtraction
   always_comb begin
      trial = {div_prev.part, div_prev.num[63]};
      diff  = trial - {1'b0, div_prev.den};
      ge    = (trial >= {1'b0, div_prev.den});
      div_in.part = ge ? diff[63:0] : trial[63:0];
      div_in.num  = {div_prev.num[62:0], 1'b0};
      div_in.den  = div_prev.den;
      div_in.quo  = {div_prev.quo[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) div_ff <= div_in;
   end

   assign div_next = div_ff;

endmodule

`default_nettype wire

// File: rtl/rmj_sqrt_cell.sv
// rmj_sqrt_cell: one digit of an integer square root, one root bit per cycle while en is high
// depends on rmj_pkg (sqrt_type)
`default_nettype none

module rmj_sqrt_cell import rmj_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type sq_prev,
   output sqrt_type sq_next
);

   sqrt_type    sq_ff;
   sqrt_type    sq_in;
   logic [35:0] acc;
   logic [35:0] trial;
   logic [35:0] diff;
   logic        ge;

   // bring down two radicand bits, test root*4+1
   always_comb begin
      acc   = {sq_prev.rem, sq_prev.rad[63:62]};
      trial = {2'b00, sq_prev.root, 2'b01};
      diff  = acc - trial;
      ge    = (acc >= trial);
      sq_in.rem  = ge ? diff[33:0] : acc[33:0];
      sq_in.root = {sq_prev.root[30:0], ge};
      sq_in.rad  = {sq_prev.rad[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) sq_ff <= sq_in;
   end

   assign sq_next = sq_ff;

endmodule

`default_nettype wire

// File: rtl/radar_measurement_jacobian.sv
// radar_measurement_jacobian: top level, pipeline of sqrt and division cells
// depends on rmj_pkg, rmj_sqrt_cell, rmj_div_cell
`default_nettype none

// Takes one tracked state (pos_x, pos_y, vel_x, vel_y, signed Q16.16) per cycle and
// returns the six distinct entries of the radar measurement Jacobian, saturated to
// Q16.16, with a too_close flag in tuser; when the squared range (Q32.32) is zero or
// below the threshold loaded from csr_wr_data (Q15.16) the entries are all zero. The
// datapath is a fixed pipeline: sign split, squares and squared range (3 stages), then
// 33 bearing division cells running beside 32 square root cells and a root register,
// 17 unit vector division cells, a product stage, a difference stage, 49 range-rate
// division cells, a rate product stage and a saturation stage, then the output
// register. A new transaction is accepted every cycle while the output side takes
// results; the bearing and range-rate divider chains make up most of the pipeline
// depth. The pipeline holds only when the output register is full and not taken
// while a finished result waits behind it.
module radar_measurement_jacobian import rmj_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [127:0]       req_tdata,   // pos_x, pos_y, vel_x, vel_y
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [191:0]       rsp_tdata,   // range_by_px, range_by_py, bearing_by_px,
                                           // bearing_by_py, rate_by_px, rate_by_py
   output logic [0:0]         rsp_tuser,   // too_close
   input  logic               csr_wr_en,
   input  logic [THR_W-1:0]   csr_wr_data
);

   localparam int SQ_N  = 32;
   localparam int BR_N  = 33;
   localparam int UV_N  = 17;
   localparam int RR_N  = 49;
   localparam int S_SQ  = 3;
   localparam int S_UV  = S_SQ + BR_N;
   localparam int S_MUL = S_UV + UV_N;
   localparam int S_RR  = S_MUL + 2;
   localparam int S_FIN = S_RR + RR_N;
   localparam int LAT   = S_FIN + 2;

   typedef struct packed {
      logic                tc;
      logic                nx;
      logic                ny;
      logic                nvx;
      logic                nvy;
      logic [31:0]         mx;
      logic [31:0]         my;
      logic [31:0]         mvx;
      logic [31:0]         mvy;
      logic [63:0]         sqx;
      logic [63:0]         sqy;
      logic [63:0]         r2;
      logic [31:0]         r;
      logic [32:0]         bx;
      logic [32:0]         by;
      logic [16:0]         ux;
      logic [16:0]         uy;
      logic [48:0]         pa;
      logic [48:0]         pb;
      logic [48:0]         tabs;
      logic                wneg;
      logic [48:0]         py1;
      logic [33:0]         py2;
      logic [48:0]         px1;
      logic [33:0]         px2;
      logic [DATA_W*6-1:0] res;
   } pipe_type;

   logic [THR_W-1:0] thr_ff;
   logic [LAT-1:0]   vld_ff;
   logic [LAT-1:0]   vld_in;
   pipe_type         pipe_ff [LAT];
   pipe_type         pipe_in [LAT];
   logic             rsp_valid_ff;
   logic [191:0]     rsp_data_ff;
   logic             rsp_tc_ff;
   logic             en;

   sqrt_type sq_chain [SQ_N+1];
   div_type  bx_chain [BR_N+1];
   div_type  by_chain [BR_N+1];
   div_type  ux_chain [UV_N+1];
   div_type  uy_chain [UV_N+1];
   div_type  w_chain  [RR_N+1];

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= THR_W'(7);
      else if (csr_wr_en) thr_ff <= csr_wr_data;
   end

   // pipeline advances unless a finished result is blocked
   assign en         = !rsp_valid_ff || rsp_tready || !vld_ff[LAT-1];
   assign req_tready = en;

   // valid bits along the pipeline
   assign vld_in = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   // chain inputs taken from pipeline registers
   always_comb begin
      sq_chain[0] = '{rem: '0, root: '0, rad: pipe_ff[2].r2};
      bx_chain[0] = '{part: {33'd0, pipe_ff[2].mx[31:1]}, num: {pipe_ff[2].mx[0], 63'd0},
                      den: pipe_ff[2].r2, quo: '0};
      by_chain[0] = '{part: {33'd0, pipe_ff[2].my[31:1]}, num: {pipe_ff[2].my[0], 63'd0},
                      den: pipe_ff[2].r2, quo: '0};
      ux_chain[0] = '{part: {33'd0, pipe_ff[S_UV-1].mx[31:1]},
                      num: {pipe_ff[S_UV-1].mx[0], 63'd0},
                      den: {32'd0, pipe_ff[S_UV-1].r}, quo: '0};
      uy_chain[0] = '{part: {33'd0, pipe_ff[S_UV-1].my[31:1]},
                      num: {pipe_ff[S_UV-1].my[0], 63'd0},
                      den: {32'd0, pipe_ff[S_UV-1].r}, quo: '0};
      w_chain[0]  = '{part: '0, num: {pipe_ff[S_RR-1].tabs, 15'd0},
                      den: {32'd0, pipe_ff[S_RR-1].r}, quo: '0};
   end

   // square root cells
   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      rmj_sqrt_cell u_cell (
         .clock   (clock),
         .en      (en),
         .sq_prev (sq_chain[j]),
         .sq_next (sq_chain[j+1])
      );
   end

   // bearing division cells, position over squared range
   for (genvar j = 0; j < BR_N; j++) begin : g_bear
      rmj_div_cell u_cell_x (
         .clock    (clock),
         .en       (en),
         .div_prev (bx_chain[j]),
         .div_next (bx_chain[j+1])
      );
      rmj_div_cell u_cell_y (
         .clock    (clock),
         .en       (en),
         .div_prev (by_chain[j]),
         .div_next (by_chain[j+1])
      );
   end

   // unit vector division cells, position over range
   for (genvar j = 0; j < UV_N; j++) begin : g_unit
      rmj_div_cell u_cell_x (
         .clock    (clock),
         .en       (en),
         .div_prev (ux_chain[j]),
         .div_next (ux_chain[j+1])
      );
      rmj_div_cell u_cell_y (
         .clock    (clock),
         .en       (en),
         .div_prev (uy_chain[j]),
         .div_next (uy_chain[j+1])
      );
   end

   // range-rate division cells, cross term over range
   for (genvar j = 0; j < RR_N; j++) begin : g_rate
      rmj_div_cell u_cell (
         .clock    (clock),
         .en       (en),
         .div_prev (w_chain[j]),
         .div_next (w_chain[j+1])
      );
   end

   // per-stage payload
   always_comb begin
      logic [31:0]  px_in;
      logic [31:0]  py_in;
      logic [31:0]  vx_in;
      logic [31:0]  vy_in;
      logic [49:0]  sa;
      logic [49:0]  sb;
      logic [50:0]  tdif;
      logic [50:0]  tneg;
      logic [65:0]  my_sum;
      logic [65:0]  mx_sum;
      pipe_type     f;
      logic [DATA_W-1:0] o0, o1, o2, o3, o4, o5;

      px_in = req_tdata[31:0];
      py_in = req_tdata[63:32];
      vx_in = req_tdata[95:64];
      vy_in = req_tdata[127:96];

      for (int k = 1; k < LAT; k++) pipe_in[k] = pipe_ff[k-1];

      // signs and magnitudes
      pipe_in[0]     = pipe_ff[0];
      pipe_in[0].nx  = px_in[31];
      pipe_in[0].ny  = py_in[31];
      pipe_in[0].nvx = vx_in[31];
      pipe_in[0].nvy = vy_in[31];
      pipe_in[0].mx  = px_in[31] ? 32'd0 - px_in : px_in;
      pipe_in[0].my  = py_in[31] ? 32'd0 - py_in : py_in;
      pipe_in[0].mvx = vx_in[31] ? 32'd0 - vx_in : vx_in;
      pipe_in[0].mvy = vy_in[31] ? 32'd0 - vy_in : vy_in;

      // squares
      pipe_in[1].sqx = 64'(pipe_ff[0].mx) * 64'(pipe_ff[0].mx);
      pipe_in[1].sqy = 64'(pipe_ff[0].my) * 64'(pipe_ff[0].my);

      // squared range and threshold test
      pipe_in[2].r2 = pipe_ff[1].sqx + pipe_ff[1].sqy;
      pipe_in[2].tc = (pipe_in[2].r2 == 64'd0) ||
                      (pipe_in[2].r2[63:FRAC_W] < 48'(thr_ff));

      // root leaves its chain at pipeline stage S_UV-1, just ahead of the bearing quotients
      pipe_in[S_UV-1].r = sq_chain[SQ_N].root;

      // bearing quotients
      pipe_in[S_UV].bx = bx_chain[BR_N].quo[32:0];
      pipe_in[S_UV].by = by_chain[BR_N].quo[32:0];

      // unit vector and velocity cross products
      pipe_in[S_MUL].ux = ux_chain[UV_N].quo[16:0];
      pipe_in[S_MUL].uy = uy_chain[UV_N].quo[16:0];
      pipe_in[S_MUL].pa = 49'(pipe_ff[S_MUL-1].mvx) * 49'(uy_chain[UV_N].quo[16:0]);
      pipe_in[S_MUL].pb = 49'(pipe_ff[S_MUL-1].mvy) * 49'(ux_chain[UV_N].quo[16:0]);

      // signed difference, kept as sign and magnitude
      f    = pipe_ff[S_MUL];
      sa   = (f.nvx != f.ny) ? 50'd0 - {1'b0, f.pa} : {1'b0, f.pa};
      sb   = (f.nvy != f.nx) ? 50'd0 - {1'b0, f.pb} : {1'b0, f.pb};
      tdif = {sa[49], sa} - {sb[49], sb};
      tneg = 51'd0 - tdif;
      pipe_in[S_MUL+1].wneg = tdif[50];
      pipe_in[S_MUL+1].tabs = tdif[50] ? tneg[48:0] : tdif[48:0];

      // rate products, split into the low 32 bits and the high 17 bits of the quotient
      pipe_in[S_FIN].py1 = 49'(pipe_ff[S_FIN-1].uy) * 49'(w_chain[RR_N].quo[31:0]);
      pipe_in[S_FIN].py2 = 34'(pipe_ff[S_FIN-1].uy) * 34'(w_chain[RR_N].quo[48:32]);
      pipe_in[S_FIN].px1 = 49'(pipe_ff[S_FIN-1].ux) * 49'(w_chain[RR_N].quo[31:0]);
      pipe_in[S_FIN].px2 = 34'(pipe_ff[S_FIN-1].ux) * 34'(w_chain[RR_N].quo[48:32]);

      // saturate and assemble
      f      = pipe_ff[S_FIN];
      my_sum = {f.py2, 32'd0} + 66'(f.py1);
      mx_sum = {f.px2, 32'd0} + 66'(f.px1);
      o0 = sat_word(f.nx, 64'(f.ux));
      o1 = sat_word(f.ny, 64'(f.uy));
      o2 = sat_word(!f.ny, 64'(f.by));
      o3 = sat_word(f.nx, 64'(f.bx));
      o4 = sat_word(f.ny != f.wneg, 64'(my_sum[65:FRAC_W]));
      o5 = sat_word(f.nx != !f.wneg, 64'(mx_sum[65:FRAC_W]));
      pipe_in[S_FIN+1].res = f.tc ? '0 : {o5, o4, o3, o2, o1, o0};
   end

   always_ff @(posedge clock) begin
      if (en) pipe_ff <= pipe_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && vld_ff[LAT-1]) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && vld_ff[LAT-1]) begin
         rsp_data_ff <= pipe_ff[LAT-1].res;
         rsp_tc_ff   <= pipe_ff[LAT-1].tc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_tc_ff;

endmodule

`default_nettype wire
